// ===== src/i2r_pkg.sv =====
// Shared types and constants of the im2row HWC address generator.
// No dependencies; every other file imports this package.
package i2r_pkg;

  // Fixed field widths
  localparam int unsigned DIMREG_W  = 13;
  localparam int unsigned FILTREG_W = 5;
  localparam int unsigned EB_W      = 4;
  localparam int unsigned STRIDE_W  = 5;
  localparam int unsigned PADF_W    = 4;
  localparam int unsigned DIL_W     = 5;
  localparam int unsigned ROWS_W    = 24;
  localparam int unsigned COLS_W    = 12;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SRC_W     = 40;
  localparam int unsigned DST_W     = 48;

  // Configuration port
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 5;
  localparam int unsigned REG_IW = 3;

  typedef enum logic [REG_IW-1:0] {
    REG_IN_ROWS       = 3'd0,
    REG_IN_COLS       = 3'd1,
    REG_CHANNELS      = 3'd2,
    REG_KERN_ROWS     = 3'd3,
    REG_KERN_COLS     = 3'd4,
    REG_OUT_ROWS      = 3'd5,
    REG_OUT_COLS      = 3'd6,
    REG_ELEMENT_BYTES = 3'd7
  } i2r_reg_e;

  typedef enum logic {
    OP_START = 1'b0,
    OP_NEXT  = 1'b1
  } i2r_op_e;

  typedef struct packed {
    logic [DIMREG_W-1:0]  in_rows;
    logic [DIMREG_W-1:0]  in_cols;
    logic [DIMREG_W-1:0]  channels;
    logic [FILTREG_W-1:0] kern_rows;
    logic [FILTREG_W-1:0] kern_cols;
    logic [DIMREG_W-1:0]  out_rows;
    logic [DIMREG_W-1:0]  out_cols;
    logic [EB_W-1:0]      element_bytes;
  } i2r_cfg_t;

  typedef struct packed {
    i2r_op_e             op;
    logic [STRIDE_W-1:0] stride_h;
    logic [STRIDE_W-1:0] stride_w;
    logic [PADF_W-1:0]   pad_h;
    logic [PADF_W-1:0]   pad_w;
    logic [DIL_W-1:0]    dil_h;
    logic [DIL_W-1:0]    dil_w;
    logic [ROWS_W-1:0]   row_stride;
    logic [COLS_W-1:0]   col_stride;
    logic [BYTE_W-1:0]   pad_value;
  } i2r_in_t;

  typedef struct packed {
    logic [SRC_W-1:0]  src_offset;
    logic [DST_W-1:0]  dst_offset;
    logic              is_padding;
    logic [BYTE_W-1:0] fill_byte;
    logic              patch_last;
    logic              job_last;
  } i2r_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic calc_hw;
    logic calc_prod;
    logic calc_sum;
    logic out_load;
  } i2r_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic job_active;
    logic out_free;
  } i2r_status_t;

endpackage

// ===== src/i2r_if.sv =====
// Valid/ready stream interfaces for the input items and the result items.
// Depends on i2r_pkg for the payload types.
interface i2r_in_if import i2r_pkg::*; ();
  logic    valid;
  logic    ready;
  i2r_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface i2r_out_if import i2r_pkg::*; ();
  logic     valid;
  logic     ready;
  i2r_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/i2r_regs.sv =====
// APB-style configuration register file of the address generator.
// Depends on i2r_pkg for the register map and the configuration struct.
module i2r_regs import i2r_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output i2r_cfg_t          cfg_o
);

  i2r_cfg_t cfg_q, cfg_d;
  i2r_reg_e idx;
  logic     wr_en;

  assign idx    = i2r_reg_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_IN_ROWS:       cfg_d.in_rows       = pwdata[DIMREG_W-1:0];
        REG_IN_COLS:       cfg_d.in_cols       = pwdata[DIMREG_W-1:0];
        REG_CHANNELS:      cfg_d.channels      = pwdata[DIMREG_W-1:0];
        REG_KERN_ROWS:     cfg_d.kern_rows     = pwdata[FILTREG_W-1:0];
        REG_KERN_COLS:     cfg_d.kern_cols     = pwdata[FILTREG_W-1:0];
        REG_OUT_ROWS:      cfg_d.out_rows      = pwdata[DIMREG_W-1:0];
        REG_OUT_COLS:      cfg_d.out_cols      = pwdata[DIMREG_W-1:0];
        REG_ELEMENT_BYTES: cfg_d.element_bytes = pwdata[EB_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_IN_ROWS:       prdata = APB_DW'(cfg_q.in_rows);
      REG_IN_COLS:       prdata = APB_DW'(cfg_q.in_cols);
      REG_CHANNELS:      prdata = APB_DW'(cfg_q.channels);
      REG_KERN_ROWS:     prdata = APB_DW'(cfg_q.kern_rows);
      REG_KERN_COLS:     prdata = APB_DW'(cfg_q.kern_cols);
      REG_OUT_ROWS:      prdata = APB_DW'(cfg_q.out_rows);
      REG_OUT_COLS:      prdata = APB_DW'(cfg_q.out_cols);
      REG_ELEMENT_BYTES: prdata = APB_DW'(cfg_q.element_bytes);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_rows       <= DIMREG_W'(1);
      cfg_q.in_cols       <= DIMREG_W'(1);
      cfg_q.channels      <= DIMREG_W'(1);
      cfg_q.kern_rows     <= FILTREG_W'(1);
      cfg_q.kern_cols     <= FILTREG_W'(1);
      cfg_q.out_rows      <= DIMREG_W'(1);
      cfg_q.out_cols      <= DIMREG_W'(1);
      cfg_q.element_bytes <= EB_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== src/i2r_ctrl.sv =====
// Sequencing state machine: takes input transactions and steps the datapath
// through its address stages. Depends on i2r_pkg for command and status.
module i2r_ctrl import i2r_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  i2r_op_e     in_op_i,
  output logic        in_ready_o,
  input  i2r_status_t status_i,
  output i2r_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADDR = 5'b00010,
    S_PROD = 5'b00100,
    S_SUM  = 5'b01000,
    S_OUT  = 5'b10000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == OP_START) begin
            cmd_o.load = 1'b1;
          end else if (status_i.job_active) begin
            cmd_o.step = 1'b1;
            state_d    = S_ADDR;
          end
        end
      end
      S_ADDR: begin
        cmd_o.calc_hw = 1'b1;
        state_d       = S_PROD;
      end
      S_PROD: begin
        cmd_o.calc_prod = 1'b1;
        state_d         = S_SUM;
      end
      S_SUM: begin
        cmd_o.calc_sum = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        // hold until the output register can take the result
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/i2r_dp.sv =====
// Datapath: job geometry, tap counters, address stages and output register.
// Depends on i2r_pkg; driven by commands from i2r_ctrl.
module i2r_dp import i2r_pkg::*; #(
  parameter int unsigned MAX_DIM    = 4096,
  parameter int unsigned MAX_FILTER = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  i2r_cfg_t    cfg_i,
  input  i2r_cmd_t    cmd_i,
  input  i2r_in_t     in_data_i,
  output i2r_status_t status_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output i2r_out_t    out_data_o
);

  localparam int unsigned DIM_W   = $clog2(MAX_DIM);
  localparam int unsigned DIM_CW  = $clog2(MAX_DIM + 1);
  localparam int unsigned FILT_W  = (MAX_FILTER > 1) ? $clog2(MAX_FILTER) : 1;
  localparam int unsigned FILT_CW = $clog2(MAX_FILTER + 1);
  localparam int unsigned PROD_W  = ((DIM_W > FILT_W) ? DIM_W : FILT_W) + STRIDE_W;
  localparam int unsigned H_W     = PROD_W + 2;
  localparam int unsigned HR_W    = DIM_W + ROWS_W;
  localparam int unsigned WC_W    = DIM_W + COLS_W;

  function automatic logic [DIM_CW-1:0] sat_dim(input logic [DIMREG_W-1:0] v);
    if (32'(v) > 32'(MAX_DIM)) sat_dim = DIM_CW'(MAX_DIM);
    else                       sat_dim = DIM_CW'(v);
  endfunction

  function automatic logic [FILT_CW-1:0] sat_filt(input logic [FILTREG_W-1:0] v);
    if (32'(v) > 32'(MAX_FILTER)) sat_filt = FILT_CW'(MAX_FILTER);
    else                          sat_filt = FILT_CW'(v);
  endfunction

  // Job geometry
  logic [STRIDE_W-1:0] stride_h_q, stride_w_q;
  logic [PADF_W-1:0]   pad_h_q, pad_w_q;
  logic [DIL_W-1:0]    dil_h_q, dil_w_q;
  logic [ROWS_W-1:0]   row_stride_q;
  logic [COLS_W-1:0]   col_stride_q;
  logic [BYTE_W-1:0]   pad_value_q;
  logic [DIM_CW-1:0]   ih_q, iw_q, ch_q, oh_q, ow_q;
  logic [FILT_CW-1:0]  fh_q, fw_q;
  logic [EB_W-1:0]     eb_q;

  // Tap counters
  logic              job_active_q, job_active_d;
  logic [DIM_W-1:0]  out_row_q, out_row_d, out_col_q, out_col_d;
  logic [FILT_W-1:0] tap_row_q, tap_row_d, tap_col_q, tap_col_d;
  logic [DIM_W-1:0]  chan_q, chan_d;
  logic [DST_W-1:0]  dest_q, dest_d;

  // Pipeline registers
  logic [DIM_W-1:0]  s_orow_q, s_ocol_q, s_chan_q;
  logic [FILT_W-1:0] s_trow_q, s_tcol_q;
  logic [DST_W-1:0]  s_dest_q;
  logic              s_patch_last_q, s_job_last_q;
  logic [H_W-1:0]    h_q, w_q;
  logic              pad_q;
  logic [HR_W-1:0]   hr_q;
  logic [WC_W-1:0]   wc_q;
  logic [SRC_W-1:0]  sum_q;
  logic [DST_W-1:0]  dst_q;

  i2r_out_t out_q;
  logic     out_valid_q;

  logic chan_end, col_end, row_end, ocol_end, orow_end, patch_end, job_end;
  logic start_ok;

  assign chan_end  = (DIM_CW'(chan_q) + DIM_CW'(1)) >= ch_q;
  assign col_end   = (FILT_CW'(tap_col_q) + FILT_CW'(1)) >= fw_q;
  assign row_end   = (FILT_CW'(tap_row_q) + FILT_CW'(1)) >= fh_q;
  assign ocol_end  = (DIM_CW'(out_col_q) + DIM_CW'(1)) >= ow_q;
  assign orow_end  = (DIM_CW'(out_row_q) + DIM_CW'(1)) >= oh_q;
  assign patch_end = chan_end && col_end && row_end;
  assign job_end   = patch_end && ocol_end && orow_end;

  assign start_ok = (cfg_i.channels != '0) && (cfg_i.kern_rows != '0) &&
                    (cfg_i.kern_cols != '0) && (cfg_i.out_rows != '0) &&
                    (cfg_i.out_cols != '0);

  always_comb begin
    job_active_d = job_active_q;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;
    tap_row_d    = tap_row_q;
    tap_col_d    = tap_col_q;
    chan_d       = chan_q;
    dest_d       = dest_q;
    if (cmd_i.load) begin
      job_active_d = start_ok;
      out_row_d    = '0;
      out_col_d    = '0;
      tap_row_d    = '0;
      tap_col_d    = '0;
      chan_d       = '0;
      dest_d       = '0;
    end else if (cmd_i.step) begin
      dest_d = dest_q + DST_W'(1);
      // advance channel first, carry outward
      if (!chan_end) begin
        chan_d = chan_q + DIM_W'(1);
      end else begin
        chan_d = '0;
        if (!col_end) begin
          tap_col_d = tap_col_q + FILT_W'(1);
        end else begin
          tap_col_d = '0;
          if (!row_end) begin
            tap_row_d = tap_row_q + FILT_W'(1);
          end else begin
            tap_row_d = '0;
            if (!ocol_end) begin
              out_col_d = out_col_q + DIM_W'(1);
            end else begin
              out_col_d = '0;
              if (!orow_end) begin
                out_row_d = out_row_q + DIM_W'(1);
              end else begin
                out_row_d    = '0;
                job_active_d = 1'b0;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_active_q <= 1'b0;
      out_row_q    <= '0;
      out_col_q    <= '0;
      tap_row_q    <= '0;
      tap_col_q    <= '0;
      chan_q       <= '0;
      dest_q       <= '0;
    end else begin
      job_active_q <= job_active_d;
      out_row_q    <= out_row_d;
      out_col_q    <= out_col_d;
      tap_row_q    <= tap_row_d;
      tap_col_q    <= tap_col_d;
      chan_q       <= chan_d;
      dest_q       <= dest_d;
    end
  end

  // Address arithmetic
  logic [PROD_W-1:0] ph_a, ph_b, pw_a, pw_b;
  logic [H_W-1:0]    h_d, w_d;
  logic              pad_d;
  logic [HR_W-1:0]   hr_d;
  logic [WC_W-1:0]   wc_d;
  logic [SRC_W-1:0]  sum_d, src_scaled;
  logic [DST_W-1:0]  dst_d;

  assign ph_a = PROD_W'(s_orow_q) * PROD_W'(stride_h_q);
  assign ph_b = PROD_W'(s_trow_q) * PROD_W'(dil_h_q);
  assign pw_a = PROD_W'(s_ocol_q) * PROD_W'(stride_w_q);
  assign pw_b = PROD_W'(s_tcol_q) * PROD_W'(dil_w_q);
  assign h_d  = H_W'(ph_a) + H_W'(ph_b) - H_W'(pad_h_q);
  assign w_d  = H_W'(pw_a) + H_W'(pw_b) - H_W'(pad_w_q);

  // sign bit set means the tap lies above or left of the input
  assign pad_d = h_q[H_W-1] || w_q[H_W-1] ||
                 (h_q[H_W-2:0] >= (H_W-1)'(ih_q)) || (w_q[H_W-2:0] >= (H_W-1)'(iw_q));
  assign hr_d  = HR_W'(h_q[DIM_W-1:0]) * HR_W'(row_stride_q);
  assign wc_d  = WC_W'(w_q[DIM_W-1:0]) * WC_W'(col_stride_q);

  assign sum_d      = SRC_W'(hr_q) + SRC_W'(wc_q) + SRC_W'(s_chan_q);
  assign dst_d      = s_dest_q * DST_W'(eb_q);
  assign src_scaled = sum_q * SRC_W'(eb_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      stride_h_q   <= in_data_i.stride_h;
      stride_w_q   <= in_data_i.stride_w;
      pad_h_q      <= in_data_i.pad_h;
      pad_w_q      <= in_data_i.pad_w;
      dil_h_q      <= in_data_i.dil_h;
      dil_w_q      <= in_data_i.dil_w;
      row_stride_q <= in_data_i.row_stride;
      col_stride_q <= in_data_i.col_stride;
      pad_value_q  <= in_data_i.pad_value;
      ih_q         <= sat_dim(cfg_i.in_rows);
      iw_q         <= sat_dim(cfg_i.in_cols);
      ch_q         <= sat_dim(cfg_i.channels);
      oh_q         <= sat_dim(cfg_i.out_rows);
      ow_q         <= sat_dim(cfg_i.out_cols);
      fh_q         <= sat_filt(cfg_i.kern_rows);
      fw_q         <= sat_filt(cfg_i.kern_cols);
      eb_q         <= cfg_i.element_bytes;
    end
    if (cmd_i.step) begin
      s_orow_q       <= out_row_q;
      s_ocol_q       <= out_col_q;
      s_trow_q       <= tap_row_q;
      s_tcol_q       <= tap_col_q;
      s_chan_q       <= chan_q;
      s_dest_q       <= dest_q;
      s_patch_last_q <= patch_end;
      s_job_last_q   <= job_end;
    end
    if (cmd_i.calc_hw) begin
      h_q <= h_d;
      w_q <= w_d;
    end
    if (cmd_i.calc_prod) begin
      pad_q <= pad_d;
      hr_q  <= hr_d;
      wc_q  <= wc_d;
    end
    if (cmd_i.calc_sum) begin
      sum_q <= sum_d;
      dst_q <= dst_d;
    end
    if (cmd_i.out_load) begin
      out_q.src_offset <= pad_q ? '0 : src_scaled;
      out_q.dst_offset <= dst_q;
      out_q.is_padding <= pad_q;
      out_q.fill_byte  <= pad_q ? pad_value_q : '0;
      out_q.patch_last <= s_patch_last_q;
      out_q.job_last   <= s_job_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_data_o          = out_q;
  assign status_o.job_active = job_active_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

`ifndef SYNTHESIS
  a_step_needs_job : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> job_active_q)
    else $error("step issued without an active job");

  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while holding a result");

  a_last_ends_job : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && s_job_last_q) |-> !job_active_q)
    else $error("job still active when its last result is issued");

  a_counters_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_active_q |-> ((DIM_CW'(chan_q) < ch_q) && (FILT_CW'(tap_col_q) < fw_q) &&
                      (FILT_CW'(tap_row_q) < fh_q) && (DIM_CW'(out_col_q) < ow_q) &&
                      (DIM_CW'(out_row_q) < oh_q)))
    else $error("tap counter outside job geometry");
`endif

endmodule

// ===== src/im2row_hwc_address_generator_unit.sv =====
// Im2row address generator for HWC tensors: one move per next transaction while a job
// is active. A next runs through four address stages (tap coordinates, row/column
// products, sum, scaling); the last one holds while the output register is still full.
// A next waits for the last result to load; starts are taken every cycle while idle.
// Reset: asynchronous active low; job idle, counters cleared, registers at 1.
module im2row_hwc_address_generator_unit import i2r_pkg::*; #(
  parameter int unsigned MAX_DIM    = 4096,
  parameter int unsigned MAX_FILTER = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  i2r_in_if.sink            in_i,
  i2r_out_if.source         out_o
);

  i2r_cfg_t    cfg;
  i2r_cmd_t    cmd;
  i2r_status_t status;

  i2r_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  i2r_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.payload.op),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  i2r_dp #(
    .MAX_DIM    (MAX_DIM),
    .MAX_FILTER (MAX_FILTER)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .in_data_i   (in_i.payload),
    .status_o    (status),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.payload)
  );

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the im2row HWC address generator: APB register writes, start and next
// transactions, a move predictor in a small scoreboard class and a check of every result.
// Depends on i2r_pkg, the i2r_in_if/i2r_out_if interfaces and the generator top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2r_pkg::*;

  localparam int unsigned DIM_CAP         = 4096;
  localparam int unsigned FILTER_CAP      = 16;
  localparam int unsigned SETTLE          = 12;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 175;
  localparam int unsigned REPORT_MAX      = 10;

  typedef longint unsigned u64_t;

  class move_scoreboard;
    int unsigned reg_val [8];
    // geometry latched at start
    int unsigned sh, sw, ph, pw, dh, dw, rstr, cstr, fill;
    int unsigned ih, iw, ch, fh, fw, oh, ow, eb;
    // walk position
    int unsigned orow, ocol, krow, kcol, chan;
    logic [DST_W-1:0] issued;
    bit busy;
    i2r_out_t pending_moves [$];
    int unsigned n_err;

    function new();
      foreach (reg_val[i]) reg_val[i] = 1;
      sh = 0; sw = 0; ph = 0; pw = 0; dh = 0; dw = 0; rstr = 0; cstr = 0; fill = 0;
      ih = 0; iw = 0; ch = 0; fh = 0; fw = 0; oh = 0; ow = 0; eb = 0;
      orow = 0; ocol = 0; krow = 0; kcol = 0; chan = 0;
      issued = '0;
      busy = 1'b0;
      n_err = 0;
    endfunction

    function int unsigned cap(int unsigned v, int unsigned lim);
      return v > lim ? lim : v;
    endfunction

    function void write_reg(i2r_reg_e idx, int unsigned v);
      case (idx)
        REG_KERN_ROWS, REG_KERN_COLS: reg_val[idx] = v & ((1 << FILTREG_W) - 1);
        REG_ELEMENT_BYTES:            reg_val[idx] = v & ((1 << EB_W) - 1);
        default:                      reg_val[idx] = v & ((1 << DIMREG_W) - 1);
      endcase
    endfunction

    function u64_t job_length();
      u64_t n;
      if (!busy) return 0;
      n = oh;
      n = n * ow * fh * fw * ch;
      return n;
    endfunction

    function void accept_item(i2r_in_t it);
      longint h, w;
      u64_t src, dst;
      bit pad, chan_end, kcol_end, krow_end, patch_end, ocol_end, orow_end;
      i2r_out_t mv;
      if (it.op == OP_START) begin
        sh = it.stride_h; sw = it.stride_w;
        ph = it.pad_h;    pw = it.pad_w;
        dh = it.dil_h;    dw = it.dil_w;
        rstr = it.row_stride; cstr = it.col_stride; fill = it.pad_value;
        ih = cap(reg_val[REG_IN_ROWS], DIM_CAP);
        iw = cap(reg_val[REG_IN_COLS], DIM_CAP);
        ch = cap(reg_val[REG_CHANNELS], DIM_CAP);
        fh = cap(reg_val[REG_KERN_ROWS], FILTER_CAP);
        fw = cap(reg_val[REG_KERN_COLS], FILTER_CAP);
        oh = cap(reg_val[REG_OUT_ROWS], DIM_CAP);
        ow = cap(reg_val[REG_OUT_COLS], DIM_CAP);
        eb = reg_val[REG_ELEMENT_BYTES];
        orow = 0; ocol = 0; krow = 0; kcol = 0; chan = 0;
        issued = '0;
        busy = ch != 0 && fh != 0 && fw != 0 && oh != 0 && ow != 0;
        return;
      end
      if (!busy) return;

      h = longint'(orow) * longint'(sh) - longint'(ph) + longint'(krow) * longint'(dh);
      w = longint'(ocol) * longint'(sw) - longint'(pw) + longint'(kcol) * longint'(dw);
      pad = h < 0 || w < 0 || h >= longint'(ih) || w >= longint'(iw);
      chan_end  = chan + 1 >= ch;
      kcol_end  = kcol + 1 >= fw;
      krow_end  = krow + 1 >= fh;
      patch_end = chan_end && kcol_end && krow_end;
      ocol_end  = ocol + 1 >= ow;
      orow_end  = orow + 1 >= oh;

      src = 0;
      if (!pad) src = (u64_t'(h) * rstr + u64_t'(w) * cstr + chan) * eb;
      dst = u64_t'(issued) * eb;

      mv.src_offset = src[SRC_W-1:0];
      mv.dst_offset = dst[DST_W-1:0];
      mv.is_padding = pad;
      mv.fill_byte  = pad ? BYTE_W'(fill) : '0;
      mv.patch_last = patch_end;
      mv.job_last   = patch_end && ocol_end && orow_end;
      pending_moves.push_back(mv);

      issued = issued + 1'b1;
      // channel innermost, then kernel column, kernel row, output column, output row
      if (!chan_end) begin
        chan++;
      end else begin
        chan = 0;
        if (!kcol_end) begin
          kcol++;
        end else begin
          kcol = 0;
          if (!krow_end) begin
            krow++;
          end else begin
            krow = 0;
            if (!ocol_end) begin
              ocol++;
            end else begin
              ocol = 0;
              if (!orow_end) begin
                orow++;
              end else begin
                orow = 0;
                busy = 1'b0;
              end
            end
          end
        end
      end
    endfunction

    function void check_move(i2r_out_t got);
      i2r_out_t want;
      if (pending_moves.size() == 0) begin
        n_err++;
        if (n_err <= REPORT_MAX)
          $display("ERROR: unexpected move src=%h dst=%h pad=%b fill=%h patch=%b job=%b",
                   got.src_offset, got.dst_offset, got.is_padding, got.fill_byte,
                   got.patch_last, got.job_last);
        return;
      end
      want = pending_moves.pop_front();
      if (got.src_offset !== want.src_offset || got.dst_offset !== want.dst_offset ||
          got.is_padding !== want.is_padding || got.fill_byte !== want.fill_byte ||
          got.patch_last !== want.patch_last || got.job_last !== want.job_last) begin
        n_err++;
        if (n_err <= REPORT_MAX) begin
          $display("ERROR: move mismatch at %0t", $realtime);
          $display("  expected src=%h dst=%h pad=%b fill=%h patch=%b job=%b",
                   want.src_offset, want.dst_offset, want.is_padding, want.fill_byte,
                   want.patch_last, want.job_last);
          $display("  actual   src=%h dst=%h pad=%b fill=%h patch=%b job=%b",
                   got.src_offset, got.dst_offset, got.is_padding, got.fill_byte,
                   got.patch_last, got.job_last);
        end
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  i2r_in_if  in_if ();
  i2r_out_if out_if ();

  im2row_hwc_address_generator_unit #(
    .MAX_DIM    (DIM_CAP),
    .MAX_FILTER (FILTER_CAP)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  move_scoreboard scb;
  int unsigned    src_pct = 0;
  int unsigned    snk_pct = 0;
  int unsigned    cycles  = 0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: check the transaction, then pick the next ready value
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) scb.check_move(out_if.payload);
    out_if.ready <= ($urandom_range(99) >= snk_pct);
  end

  // leaves valid high after acceptance; the caller either sends again or drops it
  task automatic send_item(input i2r_in_t it);
    if (src_pct != 0 && $urandom_range(99) < src_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_pct);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    scb.accept_item(it);
  endtask

  task automatic send_start(input int unsigned s_h, s_w, p_h, p_w, d_h, d_w,
                            input int unsigned r_str, c_str, pv);
    i2r_in_t it;
    it            = '0;
    it.op         = OP_START;
    it.stride_h   = STRIDE_W'(s_h);
    it.stride_w   = STRIDE_W'(s_w);
    it.pad_h      = PADF_W'(p_h);
    it.pad_w      = PADF_W'(p_w);
    it.dil_h      = DIL_W'(d_h);
    it.dil_w      = DIL_W'(d_w);
    it.row_stride = ROWS_W'(r_str);
    it.col_stride = COLS_W'(c_str);
    it.pad_value  = BYTE_W'(pv);
    send_item(it);
  endtask

  // geometry bits of a next transaction are don't-care, so randomize them
  task automatic send_next(input int unsigned n);
    logic [95:0] r;
    i2r_in_t     it;
    repeat (n) begin
      r     = {$urandom, $urandom, $urandom};
      it    = r[$bits(i2r_in_t)-1:0];
      it.op = OP_NEXT;
      send_item(it);
    end
  endtask

  // drop valid, drain all expected moves, then let in-flight work finish
  task automatic wait_quiet();
    in_if.valid <= 1'b0;
    while (scb.pending_moves.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // psel stays high between back-to-back writes; the caller drops it
  task automatic write_reg(input i2r_reg_e idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    scb.write_reg(idx, value);
  endtask

  task automatic set_geometry(input int unsigned i_h, i_w, chn, f_h, f_w, o_h, o_w, e_b);
    wait_quiet();
    write_reg(REG_IN_ROWS, i_h);
    write_reg(REG_IN_COLS, i_w);
    write_reg(REG_CHANNELS, chn);
    write_reg(REG_KERN_ROWS, f_h);
    write_reg(REG_KERN_COLS, f_w);
    write_reg(REG_OUT_ROWS, o_h);
    write_reg(REG_OUT_COLS, o_w);
    write_reg(REG_ELEMENT_BYTES, e_b);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // mostly small sizes, now and then zero, one, the clamp limit or the register maximum
  function automatic int unsigned pick_size(int unsigned hi, int unsigned lim,
                                            int unsigned top);
    if ($urandom_range(39) != 0) return $urandom_range(hi, 1);
    case ($urandom_range(3))
      0:       return 0;
      1:       return 1;
      2:       return lim;
      default: return top;
    endcase
  endfunction

  task automatic random_job(inout int unsigned fed, input bit fresh_regs);
    bit   tidy;
    u64_t taps;
    int unsigned n;
    if (fresh_regs || $urandom_range(1) == 0)
      set_geometry(pick_size(6, DIM_CAP, 8191), pick_size(6, DIM_CAP, 8191),
                   pick_size(3, DIM_CAP, 8191), pick_size(3, FILTER_CAP, 31),
                   pick_size(3, FILTER_CAP, 31), pick_size(2, DIM_CAP, 8191),
                   pick_size(2, DIM_CAP, 8191), $urandom_range(15));
    tidy = $urandom_range(3) != 0;
    if (tidy)
      send_start($urandom_range(2, 1), $urandom_range(2, 1), $urandom_range(2),
                 $urandom_range(2), $urandom_range(2, 1), $urandom_range(2, 1),
                 $urandom, $urandom, $urandom);
    else
      send_start($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom);
    taps = scb.job_length();
    if (taps == 0)
      n = 1;
    else if (taps > 60)
      n = $urandom_range(30, 1);     // abandon it, the next start restarts
    else if ($urandom_range(7) == 0)
      n = $urandom_range(int'(taps), 1);
    else
      n = int'(taps) + $urandom_range(1);
    send_next(n);
    fed += 1 + ((u64_t'(n) < taps) ? n : int'(taps));
  endtask

  int unsigned src_mix [4] = '{0, 73, 0, 23};
  int unsigned snk_mix [4] = '{0, 0, 73, 23};

  initial begin
    int unsigned fed;
    scb           = new();
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // next with no job yet
    send_next(1);
    // single-tap job with every geometry field zero; the second next finds it done
    send_start(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_next(2);
    // every geometry field at its top: the only tap falls in the padding
    send_start(31, 31, 15, 15, 31, 31, 24'hFFFFFF, 12'hFFF, 8'hFF);
    send_next(1);
    // input sizes above the clamp, widest element, large offsets
    set_geometry(8191, 8191, 2, 2, 1, 1, 1, 15);
    send_start(1, 1, 0, 0, 31, 31, 24'hFFFFFF, 12'hFFF, 8'h5A);
    send_next(4);
    // registers written during a job hold until the next start
    set_geometry(1, 1, 3, 1, 1, 1, 1, 1);
    send_start(1, 1, 0, 0, 1, 1, 5, 3, 8'h00);
    send_next(1);
    set_geometry(1, 1, 0, 1, 1, 1, 1, 8);
    send_next(2);
    // zero channels: the job is empty
    send_start(1, 1, 0, 0, 1, 1, 5, 3, 8'h11);
    send_next(1);
    // empty input, zero element size, filter above the clamp, restart mid-job
    set_geometry(0, 0, 1, 31, 16, 2, 1, 0);
    send_start(1, 1, 0, 0, 1, 1, 7, 3, 8'hC3);
    send_next(3);
    send_start(2, 2, 1, 1, 2, 2, 9, 4, 8'h3C);
    send_next(2);

    for (int p = 0; p < 4; p++) begin
      wait_quiet();
      src_pct = src_mix[p];
      snk_pct = snk_mix[p];
      fed     = 0;
      random_job(fed, 1'b1);
      while (fed < ITEMS_PER_PHASE) random_job(fed, 1'b0);
    end

    wait_quiet();
    if (scb.n_err == 0 && scb.pending_moves.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/i2r_pkg.sv
src/i2r_if.sv
src/i2r_regs.sv
src/i2r_ctrl.sv
src/i2r_dp.sv
src/im2row_hwc_address_generator_unit.sv
tb/sv/tb.sv
